/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/cfdre_pkg.sv */
// Types and constants shared by the change-flag delta record encoder.
package cfdre_pkg;

  typedef enum logic [2:0] {
    KIND_FLAGS  = 3'd0,
    KIND_TIME   = 3'd1,
    KIND_TEMP   = 3'd2,
    KIND_HUM    = 3'd3,
    KIND_TARGET = 3'd4,
    KIND_HYST   = 3'd5,
    KIND_STATUS = 3'd6
  } field_kind_e;

  localparam int unsigned NumKinds = 7;

  // Bit positions in the flags word.
  localparam int unsigned FlagTemp   = 0;
  localparam int unsigned FlagHum    = 1;
  localparam int unsigned FlagHeater = 2;
  localparam int unsigned FlagTrack  = 3;
  localparam int unsigned FlagTarget = 4;
  localparam int unsigned FlagHyst   = 5;
  localparam int unsigned FlagStatus = 6;
  localparam int unsigned FlagFull   = 7;

  localparam int unsigned QueueDepthDefault = 2;

  typedef struct packed {
    logic [7:0]         flags;
    logic [31:0]        time_diff;
    logic signed [16:0] temp_diff;
    logic signed [16:0] hum_diff;
    logic [15:0]        target;
    logic [15:0]        hyst;
    logic [7:0]         status;
  } record_t;

  // One bit per field kind still to be sent; flags and time are always present.
  function automatic logic [NumKinds-1:0] pending_mask(logic [7:0] flags);
    return {flags[FlagStatus], flags[FlagHyst], flags[FlagTarget],
            flags[FlagHum], flags[FlagTemp], 2'b11};
  endfunction

endpackage

/* sv/change_flag_delta_record_encoder_top.sv */
// Top level of the change-flag delta record encoder.
//
// Input channel: one telemetry sample per transaction (in_valid_i/in_stall_o).
// Each sample is compared with the last logged values; if anything changed or
// full_record_i is set, a record is built: flags, time difference, then one
// item per changed field. Output channel: one field item per transaction
// (out_valid_o/out_stall_i), last_field_o marks the final item of a record.
// A record passes through the record queue, the serializer's record register
// and the output register. The serializer sends one item per cycle while the
// receiver does not stall, so the items of a record (2 to 7) follow without
// gaps; samples with no change produce nothing. Samples are accepted every
// cycle while the record queue between front end and serializer (QueueDepth
// entries) has room. When the receiver stalls, the current item holds, the
// serializer waits, the queue fills and then in_stall_o rises. Reset clears
// the logged values to zero and empties the queue and the output register.
module change_flag_delta_record_encoder_top #(
  parameter int unsigned QueueDepth = cfdre_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                full_record_i,
  input  logic [31:0]         time_now_i,
  input  logic signed [15:0]  temp_now_i,
  input  logic signed [15:0]  humidity_now_i,
  input  logic [15:0]         target_now_i,
  input  logic [15:0]         hysteresis_now_i,
  input  logic [7:0]          status_now_i,
  input  logic                heater_on_i,
  input  logic                tracking_on_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          field_kind_o,
  output logic signed [32:0]  field_value_o,
  output logic                last_field_o
);
  import cfdre_pkg::*;

  record_t push_rec, pop_rec;
  logic    push, q_full, q_valid, q_pop;

  cfdre_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .full_record_i,
    .time_now_i,
    .temp_now_i,
    .humidity_now_i,
    .target_now_i,
    .hysteresis_now_i,
    .status_now_i,
    .heater_on_i,
    .tracking_on_i,
    .q_full_i (q_full),
    .push_o   (push),
    .rec_o    (push_rec)
  );

  cfdre_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (push_rec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (pop_rec)
  );

  cfdre_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_rec_i   (pop_rec),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .field_kind_o,
    .field_value_o,
    .last_field_o
  );

endmodule

/* sv/cfdre_front.sv */
// Front end: accepts samples, compares against the logged values, builds records.
module cfdre_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     full_record_i,
  input  logic [31:0]              time_now_i,
  input  logic signed [15:0]       temp_now_i,
  input  logic signed [15:0]       humidity_now_i,
  input  logic [15:0]              target_now_i,
  input  logic [15:0]              hysteresis_now_i,
  input  logic [7:0]               status_now_i,
  input  logic                     heater_on_i,
  input  logic                     tracking_on_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output cfdre_pkg::record_t       rec_o
);
  import cfdre_pkg::*;

  logic [31:0] prev_time_q, prev_time_d;
  logic [15:0] prev_temp_q, prev_temp_d;
  logic [15:0] prev_hum_q, prev_hum_d;
  logic [15:0] prev_target_q, prev_target_d;
  logic [15:0] prev_hyst_q, prev_hyst_d;
  logic [7:0]  prev_status_q, prev_status_d;
  logic        prev_heater_q, prev_heater_d;
  logic        prev_track_q, prev_track_d;

  logic [31:0] base_time;
  logic [15:0] base_temp, base_hum, base_target, base_hyst;
  logic [7:0]  base_status;
  logic        base_heater, base_track;
  logic [7:0]  flags;
  logic        emit;
  logic        accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // A full record compares against cleared memory.
  always_comb begin
    base_time   = full_record_i ? '0 : prev_time_q;
    base_temp   = full_record_i ? '0 : prev_temp_q;
    base_hum    = full_record_i ? '0 : prev_hum_q;
    base_target = full_record_i ? '0 : prev_target_q;
    base_hyst   = full_record_i ? '0 : prev_hyst_q;
    base_status = full_record_i ? '0 : prev_status_q;
    base_heater = full_record_i ? 1'b0 : prev_heater_q;
    base_track  = full_record_i ? 1'b0 : prev_track_q;
  end

  always_comb begin
    flags             = '0;
    flags[FlagTemp]   = temp_now_i != base_temp;
    flags[FlagHum]    = humidity_now_i != base_hum;
    flags[FlagHeater] = heater_on_i;
    flags[FlagTrack]  = tracking_on_i;
    flags[FlagTarget] = target_now_i != base_target;
    flags[FlagHyst]   = hysteresis_now_i != base_hyst;
    flags[FlagStatus] = status_now_i != base_status;
    flags[FlagFull]   = full_record_i;
    emit = flags[FlagTemp] | flags[FlagHum] | flags[FlagTarget] | flags[FlagHyst]
         | flags[FlagStatus] | flags[FlagFull]
         | (heater_on_i != base_heater) | (tracking_on_i != base_track);
  end

  always_comb begin
    rec_o.flags     = flags;
    rec_o.time_diff = time_now_i - base_time;
    rec_o.temp_diff = {temp_now_i[15], temp_now_i} - {base_temp[15], base_temp};
    rec_o.hum_diff  = {humidity_now_i[15], humidity_now_i} - {base_hum[15], base_hum};
    rec_o.target    = target_now_i;
    rec_o.hyst      = hysteresis_now_i;
    rec_o.status    = status_now_i;
  end

  assign push_o = accept & emit;

  // Unchanged fields already equal memory, and a full record clears it, so
  // logging every new value on an emitted record matches field-wise updates.
  always_comb begin
    prev_time_d   = prev_time_q;
    prev_temp_d   = prev_temp_q;
    prev_hum_d    = prev_hum_q;
    prev_target_d = prev_target_q;
    prev_hyst_d   = prev_hyst_q;
    prev_status_d = prev_status_q;
    prev_heater_d = prev_heater_q;
    prev_track_d  = prev_track_q;
    if (push_o) begin
      prev_time_d   = time_now_i;
      prev_temp_d   = temp_now_i;
      prev_hum_d    = humidity_now_i;
      prev_target_d = target_now_i;
      prev_hyst_d   = hysteresis_now_i;
      prev_status_d = status_now_i;
      prev_heater_d = heater_on_i;
      prev_track_d  = tracking_on_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q   <= '0;
      prev_temp_q   <= '0;
      prev_hum_q    <= '0;
      prev_target_q <= '0;
      prev_hyst_q   <= '0;
      prev_status_q <= '0;
      prev_heater_q <= 1'b0;
      prev_track_q  <= 1'b0;
    end else begin
      prev_time_q   <= prev_time_d;
      prev_temp_q   <= prev_temp_d;
      prev_hum_q    <= prev_hum_d;
      prev_target_q <= prev_target_d;
      prev_hyst_q   <= prev_hyst_d;
      prev_status_q <= prev_status_d;
      prev_heater_q <= prev_heater_d;
      prev_track_q  <= prev_track_d;
    end
  end

endmodule

/* sv/cfdre_fifo.sv */
// Record queue between the front end and the serializer.
module cfdre_fifo #(
  parameter int unsigned Depth = cfdre_pkg::QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cfdre_pkg::record_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output cfdre_pkg::record_t rdata_o
);
  import cfdre_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  record_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* sv/cfdre_back.sv */
// Serializer: sends record items one per cycle unless stalled, via an output register.
module cfdre_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cfdre_pkg::record_t   q_rec_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           field_kind_o,
  output logic signed [32:0]   field_value_o,
  output logic                 last_field_o
);
  import cfdre_pkg::*;

  record_t             rec_q, rec_d;
  logic [NumKinds-1:0] pend_q, pend_d;
  logic [NumKinds-1:0] sel_oh;
  logic [2:0]          sel_idx;
  field_kind_e         sel_kind;
  logic signed [32:0]  sel_value;
  logic                sel_last;
  logic                adv;

  logic                out_valid_q, out_valid_d;
  logic [2:0]          kind_q, kind_d;
  logic signed [32:0]  value_q, value_d;
  logic                last_q, last_d;

  // Lowest pending kind goes next.
  always_comb begin
    sel_idx = '0;
    for (int i = NumKinds - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel_idx = 3'(i);
      end
    end
    sel_kind = field_kind_e'(sel_idx);
    sel_oh   = NumKinds'(1) << sel_idx;
    sel_last = (pend_q & ~sel_oh) == '0;
  end

  always_comb begin
    case (sel_kind)
      KIND_FLAGS:  sel_value = {25'd0, rec_q.flags};
      KIND_TIME:   sel_value = {1'b0, rec_q.time_diff};
      KIND_TEMP:   sel_value = {{16{rec_q.temp_diff[16]}}, rec_q.temp_diff};
      KIND_HUM:    sel_value = {{16{rec_q.hum_diff[16]}}, rec_q.hum_diff};
      KIND_TARGET: sel_value = {17'd0, rec_q.target};
      KIND_HYST:   sel_value = {17'd0, rec_q.hyst};
      KIND_STATUS: sel_value = {25'd0, rec_q.status};
      default:     sel_value = '0;
    endcase
  end

  assign adv     = (pend_q != '0) && (!out_valid_q || !out_stall_i);
  // Load the next record when idle or as the current one sends its last item.
  assign q_pop_o = q_valid_i && ((pend_q == '0) || (adv && sel_last));

  always_comb begin
    rec_d  = rec_q;
    pend_d = pend_q;
    if (q_pop_o) begin
      rec_d  = q_rec_i;
      pend_d = pending_mask(q_rec_i.flags);
    end else if (adv) begin
      pend_d = pend_q & ~sel_oh;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    value_d     = value_q;
    last_d      = last_q;
    if (adv) begin
      out_valid_d = 1'b1;
      kind_d      = sel_idx;
      value_d     = sel_value;
      last_d      = sel_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    kind_q  <= kind_d;
    value_q <= value_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign field_kind_o  = kind_q;
  assign field_value_o = value_q;
  assign last_field_o  = last_q;

endmodule

/* sv/cfdre_checker.sv */
// Port-level checker for the encoder top level, with its bind.
`include "assert_macros.svh"

module cfdre_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                full_record_i,
  input logic [31:0]         time_now_i,
  input logic signed [15:0]  temp_now_i,
  input logic signed [15:0]  humidity_now_i,
  input logic [15:0]         target_now_i,
  input logic [15:0]         hysteresis_now_i,
  input logic [7:0]          status_now_i,
  input logic                heater_on_i,
  input logic                tracking_on_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          field_kind_o,
  input logic signed [32:0]  field_value_o,
  input logic                last_field_o
);
  import cfdre_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // Hold a stalled output transaction.
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(field_kind_o) && $stable(field_value_o) && $stable(last_field_o))

  // Within a record, items follow without gaps and in rising kind order.
  `ASSERT_NEXT(a_rec_order, out_xfer && !last_field_o, out_valid_o && (field_kind_o > $past(field_kind_o)))

  // A flags item never closes a record.
  `ASSERT_SAME(a_flags_not_last, out_valid_o && (field_kind_o == KIND_FLAGS), !last_field_o)

  // After the end of a record, the next record opens with its flags.
  `ASSERT_NEXT(a_rec_start, out_xfer && last_field_o, !out_valid_o || (field_kind_o == KIND_FLAGS))

endmodule

bind change_flag_delta_record_encoder_top cfdre_checker u_cfdre_checker (.*);

/* tb/tb_change_flag_delta_record_encoder_top.sv */
// Self-checking testbench for the change-flag delta record encoder top level.
module tb_change_flag_delta_record_encoder_top;
  import cfdre_pkg::*;

  localparam int unsigned RandomSamples = 444;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles = 16;

  typedef struct {
    logic              full;
    logic [31:0]       time_now;
    logic signed [15:0] temp;
    logic signed [15:0] hum;
    logic [15:0]       target;
    logic [15:0]       hyst;
    logic [7:0]        status;
    logic              heater;
    logic              tracking;
  } sample_t;

  typedef struct {
    field_kind_e kind;
    logic [32:0] value;
    logic        last;
  } field_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               full_record_i = 1'b0;
  logic [31:0]        time_now_i = '0;
  logic signed [15:0] temp_now_i = '0;
  logic signed [15:0] humidity_now_i = '0;
  logic [15:0]        target_now_i = '0;
  logic [15:0]        hysteresis_now_i = '0;
  logic [7:0]         status_now_i = '0;
  logic               heater_on_i = 1'b0;
  logic               tracking_on_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         field_kind_o;
  logic signed [32:0] field_value_o;
  logic               last_field_o;

  // Last logged values as the encoder should hold them.
  logic [31:0] log_time;
  logic [15:0] log_temp;
  logic [15:0] log_hum;
  logic [15:0] log_target;
  logic [15:0] log_hyst;
  logic [7:0]  log_status;
  logic        log_heater;
  logic        log_tracking;

  sample_t     pending_samples[$];
  sample_t     cur_sample;
  field_item_t expected_fields[$];
  field_item_t exp_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  change_flag_delta_record_encoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .full_record_i   (full_record_i),
    .time_now_i      (time_now_i),
    .temp_now_i      (temp_now_i),
    .humidity_now_i  (humidity_now_i),
    .target_now_i    (target_now_i),
    .hysteresis_now_i(hysteresis_now_i),
    .status_now_i    (status_now_i),
    .heater_on_i     (heater_on_i),
    .tracking_on_i   (tracking_on_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .field_kind_o    (field_kind_o),
    .field_value_o   (field_value_o),
    .last_field_o    (last_field_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic sample_t mk(logic full, logic [31:0] t, logic [15:0] temp,
                                 logic [15:0] hum, logic [15:0] target,
                                 logic [15:0] hyst, logic [7:0] status,
                                 logic heater, logic tracking);
    sample_t s;
    s.full = full;
    s.time_now = t;
    s.temp = temp;
    s.hum = hum;
    s.target = target;
    s.hyst = hyst;
    s.status = status;
    s.heater = heater;
    s.tracking = tracking;
    return s;
  endfunction

  // Keep a field half of the time, nudge it or replace it otherwise.
  function automatic logic [15:0] drift(logic [15:0] v);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) return v;
    if (pick < 8) return v + 16'($urandom_range(6)) - 16'd3;
    return 16'($urandom);
  endfunction

  function automatic sample_t next_sample(sample_t prev);
    sample_t s;
    s = prev;
    if ($urandom_range(9) == 0) begin
      // noise: every field random
      return mk(1'($urandom_range(1)), $urandom, 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 8'($urandom),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    s.full = ($urandom_range(99) < 7);
    s.time_now = ($urandom_range(15) == 0) ? 32'($urandom)
                                           : prev.time_now + 32'($urandom_range(900));
    s.temp = drift(prev.temp);
    s.hum = drift(prev.hum);
    s.target = drift(prev.target);
    s.hyst = drift(prev.hyst);
    s.status = 8'(drift({8'h00, prev.status}));
    if ($urandom_range(4) == 0) s.heater = ~prev.heater;
    if ($urandom_range(4) == 0) s.tracking = ~prev.tracking;
    return s;
  endfunction

  function automatic logic [32:0] diff16(logic [15:0] a, logic [15:0] b);
    return {{17{a[15]}}, a} - {{17{b[15]}}, b};
  endfunction

  // Build the record for one accepted sample and queue its field items.
  function automatic void encode_record(sample_t s);
    field_item_t rec[$];
    logic [7:0]  flags;
    flags = '0;
    if (s.full) begin
      log_time = '0;
      log_temp = '0;
      log_hum = '0;
      log_target = '0;
      log_hyst = '0;
      log_status = '0;
      log_heater = 1'b0;
      log_tracking = 1'b0;
      flags[FlagFull] = 1'b1;
    end
    flags[FlagTemp] = (s.temp != log_temp);
    flags[FlagHum] = (s.hum != log_hum);
    flags[FlagTarget] = (s.target != log_target);
    flags[FlagHyst] = (s.hyst != log_hyst);
    flags[FlagStatus] = (s.status != log_status);
    if (flags == '0 && s.heater == log_heater && s.tracking == log_tracking) return;
    flags[FlagHeater] = s.heater;
    flags[FlagTrack] = s.tracking;
    log_heater = s.heater;
    log_tracking = s.tracking;
    rec.push_back('{KIND_FLAGS, {25'b0, flags}, 1'b0});
    rec.push_back('{KIND_TIME, {1'b0, s.time_now - log_time}, 1'b0});
    log_time = s.time_now;
    if (flags[FlagTemp]) begin
      rec.push_back('{KIND_TEMP, diff16(s.temp, log_temp), 1'b0});
      log_temp = s.temp;
    end
    if (flags[FlagHum]) begin
      rec.push_back('{KIND_HUM, diff16(s.hum, log_hum), 1'b0});
      log_hum = s.hum;
    end
    if (flags[FlagTarget]) begin
      rec.push_back('{KIND_TARGET, {17'b0, s.target}, 1'b0});
      log_target = s.target;
    end
    if (flags[FlagHyst]) begin
      rec.push_back('{KIND_HYST, {17'b0, s.hyst}, 1'b0});
      log_hyst = s.hyst;
    end
    if (flags[FlagStatus]) begin
      rec.push_back('{KIND_STATUS, {25'b0, s.status}, 1'b0});
      log_status = s.status;
    end
    rec[rec.size() - 1].last = 1'b1;
    foreach (rec[i]) expected_fields.push_back(rec[i]);
  endfunction

  // Driver: predict on acceptance, then present the next sample or go idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) encode_record(cur_sample);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_sample = pending_samples.pop_front();
          in_valid_i <= 1'b1;
          full_record_i <= cur_sample.full;
          time_now_i <= cur_sample.time_now;
          temp_now_i <= cur_sample.temp;
          humidity_now_i <= cur_sample.hum;
          target_now_i <= cur_sample.target;
          hysteresis_now_i <= cur_sample.hyst;
          status_now_i <= cur_sample.status;
          heater_on_i <= cur_sample.heater;
          tracking_on_i <= cur_sample.tracking;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expected item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_fields.size() == 0) begin
          $error("unexpected field item: kind %0d value %0d last %0b",
                 field_kind_o, field_value_o, last_field_o);
          mismatches++;
        end else begin
          exp_item = expected_fields.pop_front();
          if (field_kind_o !== exp_item.kind) begin
            $error("field_kind: expected %0d, got %0d", exp_item.kind, field_kind_o);
            mismatches++;
          end
          if (field_value_o !== exp_item.value) begin
            $error("field_value: expected %0d, got %0d",
                   $signed(exp_item.value), field_value_o);
            mismatches++;
          end
          if (last_field_o !== exp_item.last) begin
            $error("last_field: expected %0b, got %0b", exp_item.last, last_field_o);
            mismatches++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    sample_t prev;
    int unsigned phase;
    log_time = '0;
    log_temp = '0;
    log_hum = '0;
    log_target = '0;
    log_hyst = '0;
    log_status = '0;
    log_heater = 1'b0;
    log_tracking = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed samples: no change, single bit changes, full records, extremes.
    pending_samples.push_back(mk(0, 32'd10, 0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk(0, 32'd20, 0, 0, 0, 0, 0, 1, 0));
    pending_samples.push_back(mk(0, 32'd25, 0, 0, 0, 0, 0, 1, 1));
    pending_samples.push_back(mk(1, 32'd30, 0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk(1, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF,
                                 16'hFFFF, 8'hFF, 1, 1));
    // time wraps, largest positive and negative differences
    pending_samples.push_back(mk(0, 32'd5, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                                 8'hFF, 1, 1));
    pending_samples.push_back(mk(0, 32'd9, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF,
                                 8'hFF, 1, 1));
    pending_samples.push_back(mk(0, 32'd100, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                                 8'hFF, 1, 1));
    pending_samples.push_back(mk(0, 32'd101, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                 8'hFF, 1, 1));
    pending_samples.push_back(mk(0, 32'd102, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                                 8'hFF, 1, 1));
    pending_samples.push_back(mk(0, 32'd103, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                                 8'h5A, 1, 1));
    pending_samples.push_back(mk(0, 32'd104, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                                 8'hA5, 0, 1));
    pending_samples.push_back(mk(1, 32'd104, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000,
                                 8'hA5, 0, 1));
    pending_samples.push_back(mk(1, 32'd200, 0, 0, 0, 0, 0, 1, 0));
    pending_samples.push_back(mk(0, 32'd201, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
                                 8'h01, 1, 0));
    pending_samples.push_back(mk(0, 32'd202, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                                 8'h80, 0, 0));
    pending_samples.push_back(mk(0, 32'd202, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555,
                                 8'h80, 0, 0));
    prev = pending_samples[pending_samples.size() - 1];

    // Random part in four idle profiles: none, sender, receiver, both.
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 68 : (phase == 3) ? 14 : 0;
      recv_stall_pct = (phase == 2) ? 68 : (phase == 3) ? 14 : 0;
      repeat (RandomSamples / 4) begin
        prev = next_sample(prev);
        pending_samples.push_back(prev);
      end
      while (pending_samples.size() != 0 || in_valid_i) @(posedge clk_i);
    end

    while (expected_fields.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_fields.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/cfdre_pkg.sv
sv/cfdre_front.sv
sv/cfdre_fifo.sv
sv/cfdre_back.sv
sv/change_flag_delta_record_encoder_top.sv
sv/cfdre_checker.sv
tb/tb_change_flag_delta_record_encoder_top.sv
